// File: rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types, widths and rounding helpers for the look-at view matrix block.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int IN_W     = 24;
  localparam int FRAC     = 16;
  localparam int ENT_W    = 32;

  // unit vector component, magnitude up to 2^FRAC
  localparam int VW       = FRAC + 2;
  // cross product component
  localparam int UW       = FRAC + 3;
  localparam int XP_W     = 2 * IN_W;
  localparam int PU_W     = IN_W + VW;
  localparam int DOT_W    = PU_W + 2;
  localparam int D_W      = DOT_W - FRAC + 1;
  localparam int DW_W     = D_W + VW;
  localparam int T_W      = (((IN_W + FRAC) > DW_W) ? (IN_W + FRAC) : DW_W) + 2;
  localparam int CP_W     = 2 * VW;
  localparam int RP_W     = UW + IN_W;
  localparam int RS_W     = RP_W + 2;

  // normalizer
  localparam int NORM_MSB   = 29;
  localparam int NORM_W     = NORM_MSB + 1;
  localparam int SQ_W       = 2 * NORM_W + 2;
  localparam int RT_W       = 64;
  localparam int SQRT_STEPS = 32;
  localparam int LEN_W      = 32;
  localparam int QW         = FRAC + 1;
  localparam int NUM_W      = NORM_W + FRAC + 1;
  localparam int P_W        = $clog2(T_W);
  localparam int UNIT_LAT   = 4 + SQRT_STEPS + QW + 2;
  localparam int PIPE_LAT   = 2 * UNIT_LAT + 13;

  typedef logic signed [T_W-1:0] twide_t;
  typedef logic signed [VW-1:0]  uvec_t;

  typedef struct packed {
    logic signed [IN_W-1:0] look_x;
    logic signed [IN_W-1:0] look_y;
    logic signed [IN_W-1:0] look_z;
    logic signed [IN_W-1:0] up_x;
    logic signed [IN_W-1:0] up_y;
    logic signed [IN_W-1:0] up_z;
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
  } cam_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [ENT_W-1:0] entry_0;
    logic signed [ENT_W-1:0] entry_1;
    logic signed [ENT_W-1:0] entry_2;
    logic signed [ENT_W-1:0] entry_3;
    logic                    degenerate;
    logic                    last_row;
  } row_t;

  typedef struct packed {
    logic                   ok;
    logic signed [VW-1:0]   wx;
    logic signed [VW-1:0]   wy;
    logic signed [VW-1:0]   wz;
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
    logic signed [IN_W-1:0] pz;
  } side_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // divide by 2^FRAC, half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [ENT_W-1:0] sat32(input logic signed [63:0] x);
    logic [ENT_W-1:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[ENT_W-1:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[ENT_W-1:0];
    end else begin
      r = x[ENT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/look_at_view_matrix_top.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Throughput is limited by the four-row output serializer; the pipeline itself
// takes a transaction every cycle, except when it stalls because its last stage
// holds a result that the serializer is not yet ready to load.
// Reset clears the pipeline valid bits and the output serializer only.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lavm_pkg::cam_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lavm_pkg::row_t  out_data
);
  import lavm_pkg::*;

  logic                adv;
  logic [PIPE_LAT-1:0] vv;
  logic                ser_v;
  logic [1:0]          ser_cnt;
  logic                ser_done;

  assign ser_done = ser_v && out_ready && (ser_cnt == 2'd3);
  assign adv      = !vv[PIPE_LAT-1] || !ser_v || ser_done;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (adv) begin
      vv <= {vv[PIPE_LAT-2:0], in_valid};
    end
  end

  // input stage and first normalizer
  cam_t   s0_d;
  twide_t ca [3];
  uvec_t  na [3];
  logic   oka;
  cam_t   a_d [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_d   <= in_data;
      a_d[0] <= s0_d;
      for (int k = 1; k < UNIT_LAT; k++) a_d[k] <= a_d[k-1];
    end
  end

  always_comb begin
    ca[0] = T_W'(s0_d.look_x);
    ca[1] = T_W'(s0_d.look_y);
    ca[2] = T_W'(s0_d.look_z);
  end

  lavm_unit u_norm_w (
    .clk (clk),
    .en  (adv),
    .c   (ca),
    .n   (na),
    .ok  (oka)
  );

  // w, parallel test, Gram-Schmidt
  cam_t                    c1, c2, c3, c4, c5;
  uvec_t                   w1 [3], w2 [3], w3 [3], w4 [3], w5 [3];
  logic                    ok1, ok2, ok3, ok4, ok5;
  logic signed [XP_W-1:0]  xp [6];
  logic                    par2, par3;
  logic signed [PU_W-1:0]  pu [3];
  logic signed [DOT_W-1:0] dot3;
  logic signed [D_W-1:0]   d4;
  logic signed [DW_W-1:0]  dw5 [3];
  twide_t                  t6 [3];
  side_t                   sd6;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1    <= a_d[UNIT_LAT-1];
      for (int i = 0; i < 3; i++) w1[i] <= -na[i];
      ok1   <= oka;
      xp[0] <= a_d[UNIT_LAT-1].look_y * a_d[UNIT_LAT-1].up_z;
      xp[1] <= a_d[UNIT_LAT-1].look_z * a_d[UNIT_LAT-1].up_y;
      xp[2] <= a_d[UNIT_LAT-1].look_z * a_d[UNIT_LAT-1].up_x;
      xp[3] <= a_d[UNIT_LAT-1].look_x * a_d[UNIT_LAT-1].up_z;
      xp[4] <= a_d[UNIT_LAT-1].look_x * a_d[UNIT_LAT-1].up_y;
      xp[5] <= a_d[UNIT_LAT-1].look_y * a_d[UNIT_LAT-1].up_x;

      c2    <= c1;
      w2    <= w1;
      ok2   <= ok1;
      pu[0] <= c1.up_x * w1[0];
      pu[1] <= c1.up_y * w1[1];
      pu[2] <= c1.up_z * w1[2];
      par2  <= (xp[0] == xp[1]) && (xp[2] == xp[3]) && (xp[4] == xp[5]);

      c3    <= c2;
      w3    <= w2;
      ok3   <= ok2;
      par3  <= par2;
      dot3  <= DOT_W'(pu[0]) + DOT_W'(pu[1]) + DOT_W'(pu[2]);

      c4    <= c3;
      w4    <= w3;
      ok4   <= ok3 && !par3;
      d4    <= D_W'(rnd_shift(64'(dot3)));

      c5    <= c4;
      w5    <= w4;
      ok5   <= ok4;
      for (int i = 0; i < 3; i++) dw5[i] <= d4 * w4[i];

      t6[0] <= (T_W'(c5.up_x) <<< FRAC) - T_W'(dw5[0]);
      t6[1] <= (T_W'(c5.up_y) <<< FRAC) - T_W'(dw5[1]);
      t6[2] <= (T_W'(c5.up_z) <<< FRAC) - T_W'(dw5[2]);
      sd6   <= '{ok: ok5, wx: w5[0], wy: w5[1], wz: w5[2],
                 px: c5.pos_x, py: c5.pos_y, pz: c5.pos_z};
    end
  end

  // second normalizer
  uvec_t nb [3];
  logic  okb;
  side_t b_d [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      b_d[0] <= sd6;
      for (int k = 1; k < UNIT_LAT; k++) b_d[k] <= b_d[k-1];
    end
  end

  lavm_unit u_norm_v (
    .clk (clk),
    .en  (adv),
    .c   (t6),
    .n   (nb),
    .ok  (okb)
  );

  // u = v x w and translation column
  side_t                   xb;
  side_t                   x1, x2, x3, x4, x5;
  uvec_t                   v1 [3], v2 [3], v3 [3], v4 [3], v5 [3];
  logic signed [CP_W-1:0]  vw [6];
  logic signed [CP_W:0]    df [3];
  logic signed [UW-1:0]    u3 [3], u4 [3], u5 [3];
  logic signed [RP_W-1:0]  rp [3][3];
  logic signed [RS_W-1:0]  rs [3];
  logic [3:0][3:0][ENT_W-1:0] x6_c;
  logic [3:0][3:0][ENT_W-1:0] x6_e;
  logic                    x6_deg;

  always_comb begin
    xb    = b_d[UNIT_LAT-1];
    xb.ok = b_d[UNIT_LAT-1].ok && okb;
  end

  always_comb begin
    x6_c = '0;
    if (x5.ok) begin
      for (int i = 0; i < 3; i++) begin
        x6_c[0][i] = sat32(64'(u5[i]));
        x6_c[1][i] = sat32(64'(v5[i]));
      end
      x6_c[2][0] = sat32(64'(x5.wx));
      x6_c[2][1] = sat32(64'(x5.wy));
      x6_c[2][2] = sat32(64'(x5.wz));
      for (int r = 0; r < 3; r++) x6_c[r][3] = sat32(-rnd_shift(64'(rs[r])));
    end
    x6_c[3][3] = ENT_W'(1) << FRAC;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= xb;
      v1    <= nb;
      vw[0] <= nb[1] * b_d[UNIT_LAT-1].wz;
      vw[1] <= nb[2] * b_d[UNIT_LAT-1].wy;
      vw[2] <= nb[2] * b_d[UNIT_LAT-1].wx;
      vw[3] <= nb[0] * b_d[UNIT_LAT-1].wz;
      vw[4] <= nb[0] * b_d[UNIT_LAT-1].wy;
      vw[5] <= nb[1] * b_d[UNIT_LAT-1].wx;

      x2    <= x1;
      v2    <= v1;
      df[0] <= (CP_W+1)'(vw[0]) - (CP_W+1)'(vw[1]);
      df[1] <= (CP_W+1)'(vw[2]) - (CP_W+1)'(vw[3]);
      df[2] <= (CP_W+1)'(vw[4]) - (CP_W+1)'(vw[5]);

      x3    <= x2;
      v3    <= v2;
      for (int i = 0; i < 3; i++) u3[i] <= UW'(rnd_shift(64'(df[i])));

      x4       <= x3;
      v4       <= v3;
      u4       <= u3;
      rp[0][0] <= u3[0] * x3.px;
      rp[0][1] <= u3[1] * x3.py;
      rp[0][2] <= u3[2] * x3.pz;
      rp[1][0] <= v3[0] * x3.px;
      rp[1][1] <= v3[1] * x3.py;
      rp[1][2] <= v3[2] * x3.pz;
      rp[2][0] <= x3.wx * x3.px;
      rp[2][1] <= x3.wy * x3.py;
      rp[2][2] <= x3.wz * x3.pz;

      x5 <= x4;
      v5 <= v4;
      u5 <= u4;
      for (int r = 0; r < 3; r++) begin
        rs[r] <= RS_W'(rp[r][0]) + RS_W'(rp[r][1]) + RS_W'(rp[r][2]);
      end

      x6_e   <= x6_c;
      x6_deg <= !x5.ok;
    end
  end

  // row serializer
  logic [3:0][3:0][ENT_W-1:0] rows;
  logic                       deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v   <= 1'b0;
      ser_cnt <= 2'd0;
    end else if (adv && vv[PIPE_LAT-1]) begin
      ser_v   <= 1'b1;
      ser_cnt <= 2'd0;
    end else if (ser_done) begin
      ser_v   <= 1'b0;
    end else if (ser_v && out_ready) begin
      ser_cnt <= ser_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vv[PIPE_LAT-1]) begin
      rows <= x6_e;
      deg  <= x6_deg;
    end
  end

  assign out_valid = ser_v;

  always_comb begin
    out_data.row_index  = ser_cnt;
    out_data.entry_0    = rows[ser_cnt][0];
    out_data.entry_1    = rows[ser_cnt][1];
    out_data.entry_2    = rows[ser_cnt][2];
    out_data.entry_3    = rows[ser_cnt][3];
    out_data.degenerate = deg;
    out_data.last_row   = (ser_cnt == 2'd3);
  end

endmodule

// File: rtl/lavm_unit.sv
// ----------------------------------------------------------------------------
// lavm_unit
// Pipelined 3-vector normalizer: block shift, sum of squares, one-bit-a-stage
// square root and three one-bit-a-stage dividers with rounding.
// ----------------------------------------------------------------------------
module lavm_unit (
  input  logic            clk,
  input  logic            en,
  input  lavm_pkg::twide_t c [3],
  output lavm_pkg::uvec_t  n [3],
  output logic            ok
);
  import lavm_pkg::*;

  // stage 1: magnitudes and leading one
  logic [T_W-1:0]   mag_c [3];
  logic [T_W-1:0]   any_c;
  logic [P_W-1:0]   msb_c;
  logic [T_W-1:0]   m1 [3];
  logic [2:0]       neg1;
  logic [P_W-1:0]   p1;
  logic             nz1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = c[i][T_W-1] ? T_W'(-c[i]) : T_W'(c[i]);
    end
    any_c = mag_c[0] | mag_c[1] | mag_c[2];
    msb_c = '0;
    for (int b = 0; b < T_W; b++) begin
      if (any_c[b]) msb_c = P_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= mag_c;
      for (int i = 0; i < 3; i++) neg1[i] <= c[i][T_W-1];
      p1  <= msb_c;
      nz1 <= |any_c;
    end
  end

  // stage 2: common shift that puts the largest magnitude into [2^29, 2^30)
  logic [T_W-1:0]              sh_c [3];
  logic [2:0][NORM_W-1:0]      mn2;
  logic [2:0]                  neg2;
  logic                        nz2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p1 >= P_W'(NORM_MSB)) begin
        sh_c[i] = m1[i] >> (p1 - P_W'(NORM_MSB));
      end else begin
        sh_c[i] = m1[i] << (P_W'(NORM_MSB) - p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mn2[i] <= sh_c[i][NORM_W-1:0];
      neg2 <= neg1;
      nz2  <= nz1;
    end
  end

  // stage 3: squares
  logic [2:0][2*NORM_W-1:0] sq3;
  logic [2:0][NORM_W-1:0]   mn3;
  logic [2:0]               neg3;
  logic                     nz3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= (2*NORM_W)'(mn2[i]) * (2*NORM_W)'(mn2[i]);
      end
      mn3  <= mn2;
      neg3 <= neg2;
      nz3  <= nz2;
    end
  end

  // stage 4 and square root
  logic [RT_W-1:0]          rem [SQRT_STEPS+1];
  logic [RT_W-1:0]          rt  [SQRT_STEPS+1];
  logic [2:0][NORM_W-1:0]   sm  [SQRT_STEPS+1];
  logic [2:0]               sneg [SQRT_STEPS+1];
  logic                     snz [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RT_W'(SQ_W'(sq3[0]) + SQ_W'(sq3[1]) + SQ_W'(sq3[2]));
      rt[0]   <= '0;
      sm[0]   <= mn3;
      sneg[0] <= neg3;
      snz[0]  <= nz3;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [RT_W-1:0] trial;
    assign trial = rt[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          rt[k+1]  <= (rt[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          rt[k+1]  <= rt[k] >> 1;
        end
        sm[k+1]   <= sm[k];
        sneg[k+1] <= sneg[k];
        snz[k+1]  <= snz[k];
      end
    end
  end

  // divider set-up: numerator with half divisor for rounding
  logic [LEN_W-1:0]           len;
  logic [2:0][NUM_W-1:0]      num_c;
  logic [2:0][NUM_W-1:0]      dn [QW+1];
  logic [2:0][LEN_W:0]        dr [QW+1];
  logic [2:0][QW-1:0]         dq [QW+1];
  logic [LEN_W-1:0]           dl [QW+1];
  logic [2:0]                 dneg [QW+1];
  logic                       dnz [QW+1];

  assign len = rt[SQRT_STEPS][LEN_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (NUM_W'(sm[SQRT_STEPS][i]) << FRAC) + NUM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0] <= num_c;
      for (int i = 0; i < 3; i++) begin
        dr[0][i] <= (LEN_W+1)'(num_c[i] >> QW);
      end
      dq[0]   <= '0;
      dl[0]   <= len;
      dneg[0] <= sneg[SQRT_STEPS];
      dnz[0]  <= snz[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int NB = QW - 1 - j;
    logic [2:0][LEN_W:0] r2;
    logic [2:0]          qb;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {dr[j][i][LEN_W-1:0], dn[j][i][NB]};
        qb[i] = r2[i] >= {1'b0, dl[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dr[j+1][i] <= qb[i] ? r2[i] - {1'b0, dl[j]} : r2[i];
          dq[j+1][i] <= {dq[j][i][QW-2:0], qb[i]};
        end
        dn[j+1]   <= dn[j];
        dl[j+1]   <= dl[j];
        dneg[j+1] <= dneg[j];
        dnz[j+1]  <= dnz[j];
      end
    end
  end

  // sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n[i] <= dneg[QW][i] ? VW'(-{1'b0, dq[QW][i]}) : VW'({1'b0, dq[QW][i]});
      end
      ok <= dnz[QW];
    end
  end

endmodule
